@@ src/hlm_pkg.sv @@
// Shared types and constants for the host liveness monitor.
package hlm_pkg;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_OUTCOME = 2'd1,
    ACT_STATUS  = 2'd2,
    ACT_HISTORY = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_PROBE   = 2'd0,
    KIND_CHANGE  = 2'd1,
    KIND_STATUS  = 2'd2,
    KIND_HISTORY = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_ENTRY_COUNT  = 3'd0,
    REG_ADDR_MASK    = 3'd1,
    REG_PROBE_IVL    = 3'd2,
    REG_MISS_THRESH  = 3'd3,
    REG_HISTORY_IVL  = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } back_state_t;

  localparam int unsigned CFG_WIDTH  = 32;
  localparam logic [7:0]  MISS_LIMIT = 8'd255;

  typedef struct packed {
    logic [1:0] action;
    logic       probe_alive;
    logic [3:0] entry_sel;
    logic [5:0] point_sel;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  entry_index;
    logic        is_online;
    logic [7:0]  misses;
    logic [31:0] seconds_online;
    logic [31:0] seconds_tracked;
    logic        history_bit;
    logic        history_full;
    logic [5:0]  history_next_slot;
  } out_word_t;

  // Classified command from front to back.
  typedef struct packed {
    logic [1:0] action;
    logic       probe_alive;
    logic [3:0] entry_sel;
    logic [5:0] point_sel;
    logic       add_second;
    logic       take_sample;
    logic       do_probe;
    logic [5:0] probe_entry;
  } cmd_t;

endpackage

@@ src/hlm_front.sv @@
// Front end: timers, probe selection and command queue.
module hlm_front #(
  parameter int MAX_ENTRIES   = 16,
  parameter int MS_PER_SECOND = 1000,
  parameter int QDEPTH        = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  hlm_pkg::in_word_t in_data,
  input  logic [4:0]      entry_count,
  input  logic [15:0]     probe_interval_ms,
  input  logic [31:0]     sample_period_ms,
  output logic            cmd_valid,
  input  logic            cmd_take,
  output hlm_pkg::cmd_t   cmd
);
  import hlm_pkg::*;

  localparam int EW = $clog2(MAX_ENTRIES + 1);
  localparam int PW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SW = $clog2(MS_PER_SECOND + 1);
  localparam int QW = $clog2(QDEPTH);

  logic [SW-1:0] second_ms_count;
  logic [31:0]   history_ms_count;
  logic          history_started;
  logic [15:0]   probe_ms_count;
  logic [PW-1:0] next_probe_entry;

  cmd_t          queue [QDEPTH];
  logic [QW-1:0] rd_ptr, wr_ptr;
  logic [QW:0]   fill;

  logic          accept;
  logic [EW-1:0] n_active;
  logic [SW-1:0] sec_inc;
  logic [31:0]   hist_inc;
  logic [15:0]   probe_inc;
  logic [PW-1:0] sel_entry;
  logic          probe_fire;
  cmd_t          new_cmd;

  assign in_stall  = (fill == (QW+1)'(QDEPTH));
  assign accept    = in_valid && !in_stall;
  assign cmd_valid = (fill != '0);
  assign cmd       = queue[rd_ptr];

  always_comb begin
    if (32'(entry_count) > 32'(MAX_ENTRIES)) n_active = EW'(MAX_ENTRIES);
    else n_active = EW'(entry_count);
    sec_inc   = second_ms_count + SW'(1);
    hist_inc  = (history_ms_count == '1) ? history_ms_count : history_ms_count + 32'd1;
    probe_inc = (probe_ms_count == '1) ? probe_ms_count : probe_ms_count + 16'd1;
    probe_fire = (n_active != '0) && (probe_inc >= probe_interval_ms);
    sel_entry  = (32'(next_probe_entry) >= 32'(n_active)) ? '0 : next_probe_entry;
    new_cmd             = '0;
    new_cmd.action      = in_data.action;
    new_cmd.probe_alive = in_data.probe_alive;
    new_cmd.entry_sel   = in_data.entry_sel;
    new_cmd.point_sel   = in_data.point_sel;
    if (in_data.action == ACT_TICK) begin
      new_cmd.add_second  = (32'(sec_inc) >= 32'(MS_PER_SECOND));
      new_cmd.take_sample = history_started && (hist_inc >= sample_period_ms);
      new_cmd.do_probe    = probe_fire;
      new_cmd.probe_entry = 6'(sel_entry);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) queue[wr_ptr] <= new_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
      second_ms_count  <= '0;
      history_ms_count <= '0;
      history_started  <= 1'b0;
      probe_ms_count   <= '0;
      next_probe_entry <= '0;
    end else begin
      if (accept) wr_ptr <= QW'((32'(wr_ptr) + 1) % QDEPTH);
      if (cmd_valid && cmd_take) rd_ptr <= QW'((32'(rd_ptr) + 1) % QDEPTH);
      fill <= fill + (QW+1)'(accept) - (QW+1)'(cmd_valid && cmd_take);
      if (accept && in_data.action == ACT_TICK) begin
        second_ms_count <= new_cmd.add_second ? '0 : sec_inc;
        if (!history_started) begin
          history_started  <= 1'b1;
          history_ms_count <= '0;
        end else begin
          history_ms_count <= new_cmd.take_sample ? '0 : hist_inc;
        end
        if (probe_fire) begin
          probe_ms_count   <= '0;
          next_probe_entry <= PW'((32'(sel_entry) + 1) % 16);
        end else begin
          probe_ms_count <= probe_inc;
        end
      end
    end
  end

endmodule

@@ src/hlm_back.sv @@
// Back end: per-entry state, walks, probe outcomes and reads.
module hlm_back #(
  parameter int MAX_ENTRIES   = 16,
  parameter int HISTORY_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_take,
  input  hlm_pkg::cmd_t     cmd,
  input  logic [15:0]       address_present_mask,
  input  logic [4:0]        entry_count,
  input  logic [7:0]        offline_miss_threshold,
  output logic              out_valid,
  input  logic              out_stall,
  output hlm_pkg::out_word_t out_data
);
  import hlm_pkg::*;

  localparam int PW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int HW = $clog2(HISTORY_DEPTH);
  localparam int WW = $clog2(MAX_ENTRIES + 1);

  logic                     online_flags [MAX_ENTRIES];
  logic                     online_valid [MAX_ENTRIES];
  logic [7:0]               miss_counts  [MAX_ENTRIES];
  logic [31:0]              online_secs  [MAX_ENTRIES];
  logic [31:0]              tracked_secs [MAX_ENTRIES];
  logic [HISTORY_DEPTH-1:0] history_rows [MAX_ENTRIES];
  logic [HW-1:0]            history_write_slot;
  logic                     history_wrapped;
  logic                     probe_pending;
  logic [PW-1:0]            pending_entry;

  back_state_t   state, state_next;
  cmd_t          cur;
  logic [WW-1:0] walk_idx;
  logic [WW-1:0] n_active;
  logic          walk_done;
  logic          res_valid;
  out_word_t     res;
  logic          out_free;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    if (32'(entry_count) > 32'(MAX_ENTRIES)) n_active = WW'(MAX_ENTRIES);
    else n_active = WW'(entry_count);
    walk_done = (walk_idx >= n_active);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd_valid) state_next = ST_WALK;
      ST_WALK: if (walk_done) state_next = ST_EMIT;
      ST_EMIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_take = (state == ST_IDLE) && cmd_valid;
  end

  // Result for the current command, evaluated once the walk is done.
  always_comb begin
    logic [PW-1:0] pe;
    logic [PW-1:0] se;
    logic          sel_ok;
    logic [7:0]    m_inc;
    pe     = PW'(cur.probe_entry);
    se     = PW'(cur.entry_sel);
    sel_ok = 32'(cur.entry_sel) < 32'(MAX_ENTRIES);
    m_inc  = (miss_counts[pending_entry] == MISS_LIMIT) ? MISS_LIMIT
             : miss_counts[pending_entry] + 8'd1;
    res_valid = 1'b0;
    res       = '0;
    unique case (cur.action)
      ACT_TICK: begin
        if (cur.do_probe && 32'(cur.probe_entry) < 16
            && address_present_mask[cur.probe_entry[3:0]]) begin
          res_valid       = 1'b1;
          res.kind        = KIND_PROBE;
          res.entry_index = cur.probe_entry[3:0];
          res.is_online   = online_valid[pe] && online_flags[pe];
          res.misses      = miss_counts[pe];
        end
      end
      ACT_OUTCOME: begin
        res.kind        = KIND_CHANGE;
        res.entry_index = 4'(pending_entry);
        if (probe_pending) begin
          if (cur.probe_alive) begin
            res_valid     = !online_flags[pending_entry];
            res.is_online = 1'b1;
            res.misses    = 8'd0;
          end else begin
            res_valid     = online_flags[pending_entry] && (m_inc >= offline_miss_threshold);
            res.is_online = 1'b0;
            res.misses    = m_inc;
          end
        end
      end
      ACT_STATUS: begin
        res_valid       = 1'b1;
        res.kind        = KIND_STATUS;
        res.entry_index = cur.entry_sel;
        if (sel_ok) begin
          res.is_online       = online_flags[se];
          res.misses          = miss_counts[se];
          res.seconds_online  = online_secs[se];
          res.seconds_tracked = tracked_secs[se];
        end
      end
      ACT_HISTORY: begin
        res_valid       = 1'b1;
        res.kind        = KIND_HISTORY;
        res.entry_index = cur.entry_sel;
        if (sel_ok && 32'(cur.point_sel) < 32'(HISTORY_DEPTH))
          res.history_bit = history_rows[se][HW'(cur.point_sel)];
        res.history_full      = history_wrapped;
        res.history_next_slot = 6'(history_write_slot);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      walk_idx  <= '0;
      history_write_slot <= '0;
      history_wrapped    <= 1'b0;
      probe_pending      <= 1'b0;
      pending_entry      <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        online_flags[i] <= 1'b0;
        online_valid[i] <= 1'b0;
        miss_counts[i]  <= '0;
        online_secs[i]  <= '0;
        tracked_secs[i] <= '0;
        history_rows[i] <= '0;
      end
    end else begin
      state <= state_next;
      // emit state loads its own word below
      if (out_valid && !out_stall && state != ST_EMIT) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          walk_idx <= '0;
          if (cmd_valid) cur <= cmd;
        end
        ST_WALK: begin
          // One entry a cycle for the second and history walks.
          if (!walk_done) begin
            if (cur.action == ACT_TICK && 32'(walk_idx) < 16
                && address_present_mask[walk_idx[3:0]]) begin
              if (cur.add_second) begin
                tracked_secs[PW'(walk_idx)] <= tracked_secs[PW'(walk_idx)] + 32'd1;
                if (online_flags[PW'(walk_idx)])
                  online_secs[PW'(walk_idx)] <= online_secs[PW'(walk_idx)] + 32'd1;
              end
              if (cur.take_sample)
                history_rows[PW'(walk_idx)][history_write_slot] <=
                  online_flags[PW'(walk_idx)];
            end
            walk_idx <= walk_idx + WW'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= res_valid;
            out_data  <= res;
            if (cur.action == ACT_TICK) begin
              if (cur.take_sample) begin
                if (32'(history_write_slot) == HISTORY_DEPTH - 1) begin
                  history_write_slot <= '0;
                  history_wrapped    <= 1'b1;
                end else begin
                  history_write_slot <= history_write_slot + HW'(1);
                end
              end
              if (res_valid) begin
                probe_pending <= 1'b1;
                pending_entry <= PW'(cur.probe_entry);
              end
            end else if (cur.action == ACT_OUTCOME && probe_pending) begin
              probe_pending <= 1'b0;
              online_valid[pending_entry] <= 1'b1;
              if (cur.probe_alive) begin
                miss_counts[pending_entry]  <= 8'd0;
                online_flags[pending_entry] <= 1'b1;
              end else begin
                miss_counts[pending_entry] <= res.misses;
                if (res_valid) online_flags[pending_entry] <= 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ src/host_liveness_monitor_unit.sv @@
// Top level of the host liveness monitor.
// Each accepted item is queued, then taken by the back end, walked over the entries in use and emitted.
// The back end takes a new item only once the last result is emitted, walking one entry per cycle;
//   a 4-word queue decouples input acceptance.
// Reset (rst, synchronous): registers return to their defaults, all per-entry
//   counters, flags and history clear at once, timers and the queue empty.
module host_liveness_monitor_unit #(
  parameter int MAX_ENTRIES   = 16,
  parameter int HISTORY_DEPTH = 64,
  parameter int MS_PER_SECOND = 1000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  hlm_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hlm_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import hlm_pkg::*;

  // configuration registers
  logic [4:0]  entry_count;
  logic [15:0] address_present_mask;
  logic [15:0] probe_interval_ms;
  logic [7:0]  offline_miss_threshold;
  logic [31:0] sample_period_ms;

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count            <= '0;
      address_present_mask   <= '0;
      probe_interval_ms      <= 16'd5000;
      offline_miss_threshold <= 8'd3;
      sample_period_ms       <= 32'd60000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENTRY_COUNT: entry_count            <= cfg_data[4:0];
        REG_ADDR_MASK:   address_present_mask   <= cfg_data[15:0];
        REG_PROBE_IVL:   probe_interval_ms      <= cfg_data[15:0];
        REG_MISS_THRESH: offline_miss_threshold <= cfg_data[7:0];
        REG_HISTORY_IVL: sample_period_ms       <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: timers and classification into commands
  hlm_front #(
    .MAX_ENTRIES(MAX_ENTRIES), .MS_PER_SECOND(MS_PER_SECOND), .QDEPTH(4)
  ) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .entry_count, .probe_interval_ms, .sample_period_ms,
    .cmd_valid, .cmd_take, .cmd
  );

  // back: per-entry state and result word
  hlm_back #(
    .MAX_ENTRIES(MAX_ENTRIES), .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_back (
    .clk, .rst, .cmd_valid, .cmd_take, .cmd,
    .address_present_mask, .entry_count, .offline_miss_threshold,
    .out_valid, .out_stall, .out_data
  );

  // a held result word must not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed under stall");

  // a command is only taken when one is queued
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid)
    else $error("command taken from empty queue");

  // result kinds carry zero history fields except history points
  a_kind_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != KIND_HISTORY |-> out_data.history_next_slot == '0)
    else $error("history fields set on non-history word");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the host liveness monitor.
`timescale 1ns / 100ps

module tb;
  import hlm_pkg::*;

  localparam int NUM_HOSTS   = 16;
  localparam int RING_DEPTH  = 64;
  localparam int MS_IN_SEC   = 1000;
  localparam int DRAIN_WAIT  = 200;  // queue plus one in work, with margin
  localparam int HOLD_CYCLES = 300;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;
  logic      cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  host_liveness_monitor_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the block's registers and per-host state.
  logic [4:0]  host_count;
  logic [15:0] addr_mask;
  logic [15:0] probe_ivl;
  logic [7:0]  miss_thresh;
  logic [31:0] hist_ivl;

  logic        host_up     [NUM_HOSTS];
  logic [7:0]  host_misses [NUM_HOSTS];
  logic [31:0] up_seconds  [NUM_HOSTS];
  logic [31:0] seen_seconds[NUM_HOSTS];
  logic [63:0] ring_bits   [NUM_HOSTS];
  logic [5:0]  ring_slot;
  logic        ring_wrapped;
  logic        ring_started;
  logic [31:0] ring_ms;
  logic [9:0]  sec_ms;
  logic [15:0] probe_ms;
  logic [3:0]  rr_next;
  logic        probe_waiting;
  logic [3:0]  probe_host;

  out_word_t expected_words[$];

  int errors;
  int words_sent;
  int words_checked;
  int probes_seen;
  int changes_seen;
  int send_gap_pct;
  int recv_stall_pct;
  int hold_req;
  int hold_seen;
  int hold_left;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  function automatic bit host_addressed(input int i);
    return i < 16 && addr_mask[i];
  endfunction

  function automatic out_word_t host_word(input logic [1:0] kind, input int i);
    out_word_t w;
    w = '0;
    w.kind        = kind;
    w.entry_index = i[3:0];
    w.is_online   = host_up[i];
    w.misses      = host_misses[i];
    return w;
  endfunction

  function automatic int live_hosts();
    return (int'(host_count) > NUM_HOSTS) ? NUM_HOSTS : int'(host_count);
  endfunction

  task automatic model_reset();
    host_count  = '0;
    addr_mask   = '0;
    probe_ivl   = 16'd5000;
    miss_thresh = 8'd3;
    hist_ivl    = 32'd60000;
    for (int i = 0; i < NUM_HOSTS; i++) begin
      host_up[i] = 1'b0;
      host_misses[i] = '0;
      up_seconds[i] = '0;
      seen_seconds[i] = '0;
      ring_bits[i] = '0;
    end
    ring_slot = '0;
    ring_wrapped = 1'b0;
    ring_started = 1'b0;
    ring_ms = '0;
    sec_ms = '0;
    probe_ms = '0;
    rr_next = '0;
    probe_waiting = 1'b0;
    probe_host = '0;
  endtask

  // One millisecond of time: seconds, history sampling, probe selection.
  task automatic model_tick(output bit has, output out_word_t w);
    int n;
    int pick;
    n = live_hosts();
    has = 1'b0;
    w = '0;
    sec_ms++;
    if (sec_ms >= MS_IN_SEC) begin
      sec_ms = '0;
      for (int i = 0; i < n; i++) begin
        if (host_addressed(i)) begin
          seen_seconds[i]++;
          if (host_up[i]) up_seconds[i]++;
        end
      end
    end
    if (!ring_started) begin
      ring_started = 1'b1;
      ring_ms = '0;
    end else begin
      if (ring_ms != 32'hFFFF_FFFF) ring_ms++;
      if (ring_ms >= hist_ivl) begin
        ring_ms = '0;
        for (int i = 0; i < n; i++) begin
          if (host_addressed(i)) ring_bits[i][ring_slot] = host_up[i];
        end
        ring_slot = (ring_slot == RING_DEPTH - 1) ? 6'd0 : ring_slot + 6'd1;
        if (ring_slot == 0) ring_wrapped = 1'b1;
      end
    end
    if (probe_ms != 16'hFFFF) probe_ms++;
    if (n == 0 || probe_ms < probe_ivl) return;
    probe_ms = '0;
    if (int'(rr_next) >= n) rr_next = '0;
    pick = int'(rr_next);
    rr_next = rr_next + 4'd1;
    if (!host_addressed(pick)) return;
    probe_waiting = 1'b1;
    probe_host = pick[3:0];
    w = host_word(KIND_PROBE, pick);
    has = 1'b1;
  endtask

  task automatic model_outcome(input logic alive, output bit has, output out_word_t w);
    int i;
    i = int'(probe_host);
    has = 1'b0;
    w = '0;
    if (!probe_waiting) return;
    probe_waiting = 1'b0;
    if (alive) begin
      host_misses[i] = '0;
      if (!host_up[i]) begin
        host_up[i] = 1'b1;
        has = 1'b1;
      end
    end else begin
      if (host_misses[i] != MISS_LIMIT) host_misses[i]++;
      if (host_up[i] && host_misses[i] >= miss_thresh) begin
        host_up[i] = 1'b0;
        has = 1'b1;
      end
    end
    if (has) w = host_word(KIND_CHANGE, i);
  endtask

  // Expected result of one accepted word, if any.
  task automatic model_host_step(input in_word_t d);
    bit has;
    out_word_t w;
    has = 1'b0;
    w = '0;
    case (action_t'(d.action))
      ACT_TICK:    model_tick(has, w);
      ACT_OUTCOME: model_outcome(d.probe_alive, has, w);
      ACT_STATUS: begin
        w = host_word(KIND_STATUS, int'(d.entry_sel));
        w.seconds_online  = up_seconds[d.entry_sel];
        w.seconds_tracked = seen_seconds[d.entry_sel];
        has = 1'b1;
      end
      default: begin
        w = '0;
        w.kind              = KIND_HISTORY;
        w.entry_index       = d.entry_sel;
        w.history_bit       = ring_bits[d.entry_sel][d.point_sel];
        w.history_full      = ring_wrapped;
        w.history_next_slot = ring_slot;
        has = 1'b1;
      end
    endcase
    if (has) expected_words.push_back(w);
  endtask

  // Register write; caller ends a batch with cfg_release.
  task automatic set_reg(input reg_index_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_ENTRY_COUNT: host_count  = val[4:0];
      REG_ADDR_MASK:   addr_mask   = val[15:0];
      REG_PROBE_IVL:   probe_ivl   = val[15:0];
      REG_MISS_THRESH: miss_thresh = val[7:0];
      REG_HISTORY_IVL: hist_ivl    = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic cfg_release();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Let the block drain before touching registers.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic configure(input logic [4:0] cnt, input logic [15:0] mask,
                           input logic [15:0] pivl, input logic [7:0] thr,
                           input logic [31:0] hivl);
    wait_idle();
    set_reg(REG_ENTRY_COUNT, 32'(cnt));
    set_reg(REG_ADDR_MASK, 32'(mask));
    set_reg(REG_PROBE_IVL, 32'(pivl));
    set_reg(REG_MISS_THRESH, 32'(thr));
    set_reg(REG_HISTORY_IVL, hivl);
    cfg_release();
  endtask

  // Send one word; valid stays up across back-to-back words.
  task automatic send_word(input in_word_t d);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
    model_host_step(d);
    words_sent++;
  endtask

  task automatic send_action(input action_t act, input logic alive,
                             input logic [3:0] sel, input logic [5:0] pt);
    in_word_t d;
    d.action      = act;
    d.probe_alive = alive;
    d.entry_sel   = sel;
    d.point_sel   = pt;
    send_word(d);
  endtask

  task automatic send_random(input action_t act);
    send_action(act, 1'($urandom_range(1)), 4'($urandom_range(15)),
                6'($urandom_range(63)));
  endtask

  task automatic send_ticks(input int cnt);
    repeat (cnt) send_random(ACT_TICK);
  endtask

  // Output side: stall at random or during a long hold, check each word.
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word kind", 32'(out_data.kind), '0);
        end else begin
          want = expected_words.pop_front();
          if (out_data.kind == KIND_PROBE) probes_seen++;
          if (out_data.kind == KIND_CHANGE) changes_seen++;
          if (out_data.kind !== want.kind)
            report_mismatch("kind", 32'(out_data.kind), 32'(want.kind));
          if (out_data.entry_index !== want.entry_index)
            report_mismatch("entry_index", 32'(out_data.entry_index),
                            32'(want.entry_index));
          if (out_data.is_online !== want.is_online)
            report_mismatch("is_online", 32'(out_data.is_online), 32'(want.is_online));
          if (out_data.misses !== want.misses)
            report_mismatch("misses", 32'(out_data.misses), 32'(want.misses));
          if (out_data.seconds_online !== want.seconds_online)
            report_mismatch("seconds_online", out_data.seconds_online,
                            want.seconds_online);
          if (out_data.seconds_tracked !== want.seconds_tracked)
            report_mismatch("seconds_tracked", out_data.seconds_tracked,
                            want.seconds_tracked);
          if (out_data.history_bit !== want.history_bit)
            report_mismatch("history_bit", 32'(out_data.history_bit),
                            32'(want.history_bit));
          if (out_data.history_full !== want.history_full)
            report_mismatch("history_full", 32'(out_data.history_full),
                            32'(want.history_full));
          if (out_data.history_next_slot !== want.history_next_slot)
            report_mismatch("history_next_slot", 32'(out_data.history_next_slot),
                            32'(want.history_next_slot));
        end
      end
      // A hold request starts a fixed stall window counted here.
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Reset defaults, then small intervals: probes, changes, reads, ring.
  task automatic test_basic_flow();
    send_random(ACT_STATUS);
    send_random(ACT_HISTORY);
    configure(5'd4, 16'h000B, 16'd1, 8'd1, 32'd1);
    send_ticks(3);
    send_action(ACT_OUTCOME, 1'b1, 4'd0, 6'd0);   // host comes up
    send_random(ACT_TICK);
    send_action(ACT_OUTCOME, 1'b0, 4'd15, 6'd63); // miss on a host that is down: no change
    send_action(ACT_OUTCOME, 1'b1, 4'd0, 6'd0);   // outcome with nothing pending
    send_ticks(2);                                 // wrap back to entry 0, then entry 1
    send_random(ACT_TICK);
    send_ticks(1);                                 // new pick replaces pending one
    send_action(ACT_OUTCOME, 1'b1, 4'd0, 6'd0);
    send_action(ACT_STATUS, 1'b0, 4'd0, 6'd0);
    send_action(ACT_STATUS, 1'b1, 4'd15, 6'd63);
    send_action(ACT_HISTORY, 1'b0, 4'd0, 6'd0);
    send_action(ACT_HISTORY, 1'b1, 4'd15, 6'd63);
  endtask

  // Zero hosts, zero intervals, zero threshold, clamped count, extremes.
  task automatic test_edge_settings();
    configure(5'd0, 16'hFFFF, 16'd2, 8'd3, 32'd5);
    send_ticks(4);                                 // no host: only time advances
    configure(5'd31, 16'hFFFF, 16'd0, 8'd0, 32'd0);
    send_ticks(3);
    send_action(ACT_OUTCOME, 1'b1, 4'd0, 6'd0);
    send_random(ACT_TICK);
    send_action(ACT_OUTCOME, 1'b0, 4'd0, 6'd0);
    send_random(ACT_HISTORY);
    configure(5'd16, 16'h8001, 16'd65535, 8'd255, 32'hFFFF_FFFF);
    send_ticks(3);
    send_random(ACT_STATUS);
  endtask

  // Repeated misses on one host: threshold 255 and miss count saturation.
  task automatic test_miss_saturation();
    configure(5'd1, 16'h0001, 16'd1, 8'd255, 32'd7);
    send_random(ACT_TICK);
    send_action(ACT_OUTCOME, 1'b1, 4'd0, 6'd0);
    repeat (260) begin
      send_random(ACT_TICK);
      send_action(ACT_OUTCOME, 1'b0, 4'd0, 6'd0);
    end
    send_action(ACT_STATUS, 1'b0, 4'd0, 6'd0);
  endtask

  // Output held off while reads keep coming: the input must back up.
  task automatic test_output_backpressure();
    configure(5'd16, 16'hFFFF, 16'd3, 8'd2, 32'd4);
    hold_req++;
    repeat (30) send_random(($urandom_range(1) != 0) ? ACT_STATUS : ACT_HISTORY);
  endtask

  // Mostly well-formed probe cycles with random content, plus noise.
  task automatic test_random_traffic(input int cnt);
    int r;
    for (int k = 0; k < cnt; k++) begin
      r = $urandom_range(99);
      if (probe_waiting && r < 45) send_random(ACT_OUTCOME);
      else if (r < 72) send_random(ACT_TICK);
      else if (r < 80) send_random(ACT_OUTCOME);
      else if (r < 90) send_random(ACT_STATUS);
      else send_random(ACT_HISTORY);
    end
  endtask

  task automatic random_setting();
    configure(5'($urandom_range(31)), 16'($urandom_range(16'hFFFF)),
              16'($urandom_range(6)), 8'($urandom_range(4)), $urandom_range(12));
  endtask

  initial begin
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    probes_seen = 0;
    changes_seen = 0;
    hold_req = 0;
    send_gap_pct = 25;
    recv_stall_pct = 60;
    model_reset();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_ENTRY_COUNT;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_flow();
    test_edge_settings();
    test_miss_saturation();
    test_output_backpressure();

    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct   = (ph == 0) ? 25 : (ph == 1) ? 60 : 0;
      recv_stall_pct = (ph == 0) ? 60 : (ph == 1) ? 25 : 0;
      for (int s = 0; s < 4; s++) begin
        random_setting();
        test_random_traffic(120);
      end
    end

    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d input words and %0d result words (%0d probes, %0d changes),",
             words_sent, words_checked, probes_seen, changes_seen);
    $display("with edge register values, miss saturation and a long output hold.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
